/* design/fbpa_pkg.sv */
// Package for the fixed block pool allocator.
// Holds opcodes, status codes, register indexes and the controller/datapath
// interface structs. No dependencies.
package fbpa_pkg;

	localparam logic [1:0] OP_INIT       = 2'd0;
	localparam logic [1:0] OP_ALLOC      = 2'd1;
	localparam logic [1:0] OP_ALLOC_WAIT = 2'd2;
	localparam logic [1:0] OP_FREE       = 2'd3;

	localparam logic [2:0] STAT_OK         = 3'd0;
	localparam logic [2:0] STAT_EMPTY      = 3'd1;
	localparam logic [2:0] STAT_BLOCKED    = 3'd2;
	localparam logic [2:0] STAT_BAD_PTR    = 3'd3;
	localparam logic [2:0] STAT_INIT_FAIL  = 3'd4;
	localparam logic [2:0] STAT_QUEUE_FULL = 3'd5;

	localparam logic [1:0] REG_POOL_BASE   = 2'd0;
	localparam logic [1:0] REG_BLOCK_BYTES = 2'd1;
	localparam logic [1:0] REG_ALIGN_EIGHT = 2'd2;
	localparam logic [1:0] REG_BLOCK_COUNT = 2'd3;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic latch;        // capture the input item
		logic init_setup;   // round sizes, form the pool size
		logic init_chk;     // post failure result if the sizes do not fit
		logic free_start;   // range check, load the offset
		logic alloc_start;  // pop check, queue the task when empty
		logic step;         // one subtract step of the index search
		logic init_commit;  // install the new pool
		logic free_commit;  // push the block or hand it to a waiter
		logic alloc_fin;    // finish the pop
		logic load_out;     // move the result into the output register
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [1:0] op;
		logic       init_fail;
		logic       free_bad;
		logic       pool_empty;
		logic       loop_done;
		logic       out_free;
	} stat_t;

endpackage

/* design/fixed_block_pool_allocator_unit.sv */
// Top level of the fixed block pool allocator.
// Depends on fbpa_pkg, fbpa_ctrl and fbpa_dpath (which uses fbpa_ram).
//
// Usage: requests enter on the s_* stream channel, one item at a time, and
// each request gives exactly one result item on the m_* channel. Opcodes are
// init, alloc without wait, alloc with wait, and free. The pool geometry is
// set through the APB port before an init; write it only while the block is
// idle. Alloc and free pop or push a LIFO list of block indexes kept in a
// small link RAM; alloc with wait on an empty pool queues the task in a
// priority-ordered register queue, and a later free hands its block to the
// head of that queue.
// A free finds the block index by one subtraction of the block size per
// cycle. Init uses the same subtract loop to count the blocks and writes
// one link per cycle. Failed checks finish early.
// A new item is accepted once the previous result sits in the output
// register, so a stalled receiver holds one result there and the block
// works on the next item; it waits only if a second result is ready.
// Reset empties the pool, the wait queue and the output register; blocks
// are unusable until an init succeeds.
module fixed_block_pool_allocator_unit import fbpa_pkg::*; #(
	parameter int NUM_BLOCKS   = 32,
	parameter int MAX_WAITERS  = 16,
	parameter int HEADER_BYTES = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	// Request stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	// opcode[1:0], address[33:2], task_id[41:34], task_priority[49:42], zero fill
	input  logic [55:0] s_tdata,
	// Result stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	// status[2:0], block_address[34:3], woken_valid[35], woken_task[43:36], zero fill
	output logic [47:0] m_tdata,
	// Configuration port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cmd_t  cmd;
	stat_t st;
	logic  cfg_we;

	assign pready = 1'b1;
	// A register is written in the access phase of a write transfer.
	assign cfg_we = psel && penable && pwrite && pready;

	fbpa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	fbpa_dpath #(
		.NUM_BLOCKS   (NUM_BLOCKS),
		.MAX_WAITERS  (MAX_WAITERS),
		.HEADER_BYTES (HEADER_BYTES)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.in_data   (s_tdata),
		.cfg_we    (cfg_we),
		.cfg_idx   (paddr[3:2]),
		.cfg_wdata (pwdata),
		.cfg_rdata (prdata),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

endmodule

/* design/fbpa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fbpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* design/fbpa_ctrl.sv */
// Controller state machine of the fixed block pool allocator.
// Depends on fbpa_pkg for the command and status structs and opcodes.
module fbpa_ctrl import fbpa_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  stat_t st,
	output cmd_t  cmd
);

	localparam logic [2:0] S_IDLE      = 3'd0;
	localparam logic [2:0] S_START     = 3'd1;
	localparam logic [2:0] S_INIT_CHK  = 3'd2;
	localparam logic [2:0] S_INIT_LOOP = 3'd3;
	localparam logic [2:0] S_FREE_LOOP = 3'd4;
	localparam logic [2:0] S_ALLOC_FIN = 3'd5;
	localparam logic [2:0] S_DONE      = 3'd6;

	logic [2:0] state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d = S_START;
				end
			end
			S_START: begin
				case (st.op)
					OP_INIT: begin
						cmd.init_setup = 1'b1;
						state_d = S_INIT_CHK;
					end
					OP_FREE: begin
						cmd.free_start = 1'b1;
						state_d = st.free_bad ? S_DONE : S_FREE_LOOP;
					end
					default: begin
						cmd.alloc_start = 1'b1;
						state_d = st.pool_empty ? S_DONE : S_ALLOC_FIN;
					end
				endcase
			end
			S_INIT_CHK: begin
				cmd.init_chk = 1'b1;
				state_d = st.init_fail ? S_DONE : S_INIT_LOOP;
			end
			S_INIT_LOOP: begin
				if (st.loop_done) begin
					cmd.init_commit = 1'b1;
					state_d = S_DONE;
				end else begin
					cmd.step = 1'b1;
				end
			end
			S_FREE_LOOP: begin
				if (st.loop_done) begin
					cmd.free_commit = 1'b1;
					state_d = S_DONE;
				end else begin
					cmd.step = 1'b1;
				end
			end
			S_ALLOC_FIN: begin
				cmd.alloc_fin = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (st.out_free) begin
					cmd.load_out = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* design/fbpa_dpath.sv */
// Datapath of the fixed block pool allocator: configuration registers, pool
// state, priority wait queue, index search and output register.
// Depends on fbpa_pkg and fbpa_ram.
module fbpa_dpath import fbpa_pkg::*; #(
	parameter int NUM_BLOCKS   = 32,
	parameter int MAX_WAITERS  = 16,
	parameter int HEADER_BYTES = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output stat_t       st,
	input  logic [55:0] in_data,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [31:0] cfg_wdata,
	output logic [31:0] cfg_rdata,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [47:0] out_data
);

	localparam int IW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
	localparam int CW = $clog2(NUM_BLOCKS + 1);
	localparam int WW = $clog2(MAX_WAITERS + 1);
	localparam int HDR4 = (HEADER_BYTES + 3) / 4 * 4;
	localparam int HDR8 = (HEADER_BYTES + 7) / 8 * 8;
	localparam int HW = $clog2(HDR8 + 1);

	// Configuration registers.
	logic [31:0] pool_base_q;
	logic [15:0] block_bytes_q;
	logic        align_eight_q;
	logic [5:0]  block_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_base_q   <= '0;
			block_bytes_q <= '0;
			align_eight_q <= 1'b0;
			block_count_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_POOL_BASE:   pool_base_q   <= cfg_wdata;
				REG_BLOCK_BYTES: block_bytes_q <= cfg_wdata[15:0];
				REG_ALIGN_EIGHT: align_eight_q <= cfg_wdata[0];
				REG_BLOCK_COUNT: block_count_q <= cfg_wdata[5:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_POOL_BASE:   cfg_rdata = pool_base_q;
			REG_BLOCK_BYTES: cfg_rdata = {16'd0, block_bytes_q};
			REG_ALIGN_EIGHT: cfg_rdata = {31'd0, align_eight_q};
			REG_BLOCK_COUNT: cfg_rdata = {26'd0, block_count_q};
			default:         cfg_rdata = '0;
		endcase
	end

	// Latched item.
	logic [1:0]  op_q;
	logic [31:0] addr_q;
	logic [7:0]  id_q;
	logic [7:0]  prio_q;

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q   <= in_data[1:0];
			addr_q <= in_data[33:2];
			id_q   <= in_data[41:34];
			prio_q <= in_data[49:42];
		end
	end

	// Pool state.
	logic [15:0]   rs_q;
	logic [HW-1:0] hdr_q;
	logic [CW-1:0] usable_q;
	logic [CW-1:0] fcnt_q;
	logic [IW-1:0] head_q;
	logic [WW-1:0] wcnt_q;
	logic [15:0]   wq_q [MAX_WAITERS];

	// Work registers.
	logic [16:0]   cand_rs_q;
	logic [HW-1:0] cand_hdr_q;
	logic [22:0]   pool_q;
	logic [32:0]   rem_q;
	logic [CW-1:0] cnt_q;
	logic [31:0]   mult_q;

	// Result and output registers.
	logic [2:0]  res_status_q;
	logic [31:0] res_addr_q;
	logic        res_wv_q;
	logic [7:0]  res_wt_q;
	logic        out_valid_q;
	logic [47:0] out_data_q;

	// Link memory.
	logic          link_we;
	logic [IW-1:0] link_waddr;
	logic [IW-1:0] link_wdata;
	logic [IW-1:0] link_rdata;

	fbpa_ram #(.WIDTH(IW), .DEPTH(NUM_BLOCKS)) u_link (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.raddr (head_q),
		.rdata (link_rdata)
	);

	logic [32:0]   start_addr;
	logic [32:0]   rs_ext;
	logic          step_ok;
	logic [CW-1:0] limit;
	logic          free_bad_idx;
	logic [16:0]   rs_round;

	assign start_addr = {1'b0, pool_base_q} + 33'(hdr_q);
	assign rs_ext     = (op_q == OP_INIT) ? {16'd0, cand_rs_q} : {17'd0, rs_q};
	assign limit      = (op_q == OP_INIT) ? CW'(NUM_BLOCKS) : usable_q;
	assign step_ok    = (rem_q >= rs_ext) && (cnt_q < limit);
	assign free_bad_idx = (rem_q != '0) || (cnt_q >= usable_q);
	assign rs_round   = align_eight_q ? ((17'(block_bytes_q) + 17'd7) & ~17'd7)
	                                  : ((17'(block_bytes_q) + 17'd3) & ~17'd3);

	assign st.op         = op_q;
	assign st.init_fail  = (cand_rs_q == '0) || (cand_rs_q > 17'd65535) ||
	                       (23'(cand_rs_q) + 23'(cand_hdr_q) > pool_q);
	assign st.free_bad   = (usable_q == '0) || (rs_q == '0) ||
	                       ({1'b0, addr_q} < start_addr) || (fcnt_q >= usable_q);
	assign st.pool_empty = (fcnt_q == '0);
	assign st.loop_done  = !step_ok;
	assign st.out_free   = !out_valid_q || out_ready;

	always_comb begin
		link_we    = 1'b0;
		link_waddr = cnt_q[IW-1:0];
		link_wdata = IW'(cnt_q + CW'(1));
		if (cmd.step && op_q == OP_INIT) begin
			link_we = 1'b1;
		end else if (cmd.free_commit && !free_bad_idx && wcnt_q == '0) begin
			link_we    = 1'b1;
			link_wdata = (fcnt_q == '0) ? '0 : head_q;
		end
	end

	// Wait queue: an entry is ahead of the new task when its priority is at
	// least as high, so equal priorities keep arrival order.
	logic [MAX_WAITERS-1:0] ge;
	always_comb begin
		for (int i = 0; i < MAX_WAITERS; i++) begin
			ge[i] = (WW'(i) < wcnt_q) && (wq_q[i][15:8] >= prio_q);
		end
	end

	logic do_enq, do_deq;
	assign do_enq = cmd.alloc_start && st.pool_empty && op_q == OP_ALLOC_WAIT &&
	                wcnt_q < WW'(MAX_WAITERS);
	assign do_deq = cmd.free_commit && !free_bad_idx && wcnt_q != '0;

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_WAITERS; i++) begin
			if (do_enq && !ge[i]) begin
				if (i == 0) begin
					wq_q[i] <= {prio_q, id_q};
				end else if (ge[i-1]) begin
					wq_q[i] <= {prio_q, id_q};
				end else begin
					wq_q[i] <= wq_q[i-1];
				end
			end else if (do_deq && i < MAX_WAITERS - 1) begin
				wq_q[i] <= wq_q[i+1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rs_q     <= '0;
			hdr_q    <= '0;
			usable_q <= '0;
			fcnt_q   <= '0;
			head_q   <= '0;
			wcnt_q   <= '0;
		end else begin
			if (cmd.init_commit) begin
				rs_q     <= cand_rs_q[15:0];
				hdr_q    <= cand_hdr_q;
				usable_q <= cnt_q;
				fcnt_q   <= cnt_q;
				head_q   <= '0;
				wcnt_q   <= '0;
			end
			if (do_enq) begin
				wcnt_q <= wcnt_q + WW'(1);
			end
			if (do_deq) begin
				wcnt_q <= wcnt_q - WW'(1);
			end
			if (cmd.free_commit && !free_bad_idx && wcnt_q == '0) begin
				head_q <= cnt_q[IW-1:0];
				fcnt_q <= fcnt_q + CW'(1);
			end
			if (cmd.alloc_fin) begin
				fcnt_q <= fcnt_q - CW'(1);
				head_q <= (fcnt_q == CW'(1)) ? '0 : link_rdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.init_setup) begin
			cand_rs_q  <= rs_round;
			cand_hdr_q <= align_eight_q ? HW'(HDR8) : HW'(HDR4);
			pool_q     <= 23'(HEADER_BYTES) + 23'(block_bytes_q) * 23'(block_count_q);
		end
		if (cmd.init_chk) begin
			rem_q <= 33'(pool_q - 23'(cand_hdr_q));
			cnt_q <= '0;
		end
		if (cmd.free_start) begin
			rem_q <= {1'b0, addr_q} - start_addr;
			cnt_q <= '0;
		end
		if (cmd.step) begin
			rem_q <= rem_q - rs_ext;
			cnt_q <= cnt_q + CW'(1);
		end
		if (cmd.alloc_start) begin
			mult_q <= 32'(head_q) * 32'(rs_q);
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			res_status_q <= STAT_OK;
			res_addr_q   <= '0;
			res_wv_q     <= 1'b0;
			res_wt_q     <= '0;
		end
		if (cmd.init_chk && st.init_fail) begin
			res_status_q <= STAT_INIT_FAIL;
		end
		if (cmd.free_start && st.free_bad) begin
			res_status_q <= STAT_BAD_PTR;
		end
		if (cmd.free_commit) begin
			if (free_bad_idx) begin
				res_status_q <= STAT_BAD_PTR;
			end else if (wcnt_q != '0) begin
				res_addr_q <= addr_q;
				res_wv_q   <= 1'b1;
				res_wt_q   <= wq_q[0][7:0];
			end
		end
		if (cmd.alloc_start && st.pool_empty) begin
			if (op_q == OP_ALLOC) begin
				res_status_q <= STAT_EMPTY;
			end else if (wcnt_q >= WW'(MAX_WAITERS)) begin
				res_status_q <= STAT_QUEUE_FULL;
			end else begin
				res_status_q <= STAT_BLOCKED;
			end
		end
		if (cmd.alloc_fin) begin
			res_addr_q <= start_addr[31:0] + mult_q;
		end
		if (cmd.load_out) begin
			out_data_q <= {4'd0, res_wt_q, res_wv_q, res_addr_q, res_status_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

/* verif/tb_fixed_block_pool_allocator_unit.sv */
`timescale 1ns / 1ps
// Self-checking testbench for fixed_block_pool_allocator_unit: pool geometry writes, init,
// allocs, frees and the priority wait queue are predicted in place and checked per item.
// Depends on fbpa_pkg and the allocator RTL only.
module tb_fixed_block_pool_allocator_unit;
	import fbpa_pkg::*;

	localparam int POOL_SLOTS     = 32;
	localparam int WAIT_SLOTS     = 16;
	localparam int HDR_BYTES      = 12;
	localparam int RANDOM_ITEMS   = 1400;
	localparam int WATCHDOG_LIMIT = 20000;

	// One result item as the block reports it.
	typedef struct {
		logic [2:0]  status;
		logic [31:0] block_address;
		logic        woken_valid;
		logic [7:0]  woken_task;
	} grant_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	// opcode[1:0], address[33:2], task_id[41:34], task_priority[49:42], zero fill
	logic [55:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// status[2:0], block_address[34:3], woken_valid[35], woken_task[43:36], zero fill
	logic [47:0] m_tdata;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	fixed_block_pool_allocator_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Shadow copy of the pool: geometry registers and the allocator state.
	logic [31:0] geo_base;
	logic [15:0] geo_bytes;
	logic        geo_eight;
	logic [5:0]  geo_count;
	int unsigned link_of [POOL_SLOTS];
	int unsigned head_idx;
	bit          list_empty;
	int unsigned blocks_usable;
	int unsigned block_stride;
	int unsigned header_stride;
	int unsigned blocks_free;
	logic [15:0] waiters [WAIT_SLOTS];
	int unsigned waiter_total;

	grant_t      pending_grants[$];
	logic [31:0] held_blocks[$];
	int          mismatches = 0;
	int          items_sent = 0;
	int          burst_left = 0;

	// Address of block idx; the sum wraps to 32 bits like the hardware's.
	function automatic logic [31:0] block_at(int unsigned idx);
		return geo_base + header_stride + idx * block_stride;
	endfunction

	// Computes the result of one request and advances the shadow state.
	function automatic grant_t predict_grant(logic [1:0] op, logic [31:0] addr,
			logic [7:0] id, logic [7:0] prio);
		grant_t      g;
		int unsigned rs, hdr, idx, pos;
		longint      pool, start, off;
		g = '{STAT_OK, 32'd0, 1'b0, 8'd0};
		if (op == OP_INIT) begin
			rs   = geo_eight ? ((geo_bytes + 7) & ~7) : ((geo_bytes + 3) & ~3);
			hdr  = geo_eight ? 16 : 12;
			// The align flag does not enter the pool size.
			pool = HDR_BYTES + longint'(geo_bytes) * geo_count;
			if (rs == 0 || rs > 65535 || longint'(rs + hdr) > pool) begin
				g.status = STAT_INIT_FAIL;
				return g;
			end
			blocks_usable = 32'((pool - hdr) / rs);
			if (blocks_usable > POOL_SLOTS)
				blocks_usable = POOL_SLOTS;
			block_stride  = rs;
			header_stride = hdr;
			for (int i = 0; i < POOL_SLOTS; i++)
				link_of[i] = (i + 1 < blocks_usable) ? i + 1 : 0;
			head_idx     = 0;
			blocks_free  = blocks_usable;
			list_empty   = (blocks_free == 0);
			waiter_total = 0;
			return g;
		end
		if (op == OP_FREE) begin
			start = longint'(geo_base) + header_stride;
			if (blocks_usable == 0 || block_stride == 0 || longint'(addr) < start) begin
				g.status = STAT_BAD_PTR;
				return g;
			end
			off = longint'(addr) - start;
			idx = 32'(off / block_stride);
			if (off % block_stride != 0 || off / block_stride >= blocks_usable
					|| blocks_free >= blocks_usable) begin
				g.status = STAT_BAD_PTR;
				return g;
			end
			if (waiter_total > 0) begin
				// The block goes straight to the head waiter; the list is untouched.
				g.block_address = addr;
				g.woken_valid   = 1'b1;
				g.woken_task    = waiters[0][7:0];
				for (int i = 1; i < waiter_total; i++)
					waiters[i - 1] = waiters[i];
				waiter_total--;
				return g;
			end
			link_of[idx] = list_empty ? 0 : head_idx;
			head_idx     = idx;
			blocks_free++;
			list_empty   = 1'b0;
			return g;
		end
		// Both alloc flavors try to pop first.
		if (!list_empty && blocks_free != 0) begin
			idx = head_idx;
			blocks_free--;
			if (blocks_free == 0) begin
				list_empty = 1'b1;
				head_idx   = 0;
			end else begin
				head_idx = link_of[idx] % POOL_SLOTS;
			end
			g.block_address = block_at(idx);
			return g;
		end
		if (op == OP_ALLOC) begin
			g.status = STAT_EMPTY;
			return g;
		end
		if (waiter_total >= WAIT_SLOTS) begin
			g.status = STAT_QUEUE_FULL;
			return g;
		end
		// Insert behind every waiter of equal or higher priority.
		pos = 0;
		while (pos < waiter_total && waiters[pos][15:8] >= prio)
			pos++;
		for (int i = waiter_total; i > pos; i--)
			waiters[i] = waiters[i - 1];
		waiters[pos] = {prio, id};
		waiter_total++;
		g.status = STAT_BLOCKED;
		return g;
	endfunction

	// Sends one request, working in bursts with random gaps between them. The
	// expectation is formed at the edge where the block takes the item, so the
	// shadow state follows acceptance order.
	task automatic issue_request(logic [1:0] op, logic [31:0] addr, logic [7:0] id,
			logic [7:0] prio);
		grant_t g;
		int     gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			// Mostly short bursts, now and then a long stretch with no gaps.
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
			                                         : $urandom_range(1, 12);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= {6'd0, prio, id, addr, op};
		do @(posedge clk); while (!(s_tvalid && s_tready));
		g = predict_grant(op, addr, id, prio);
		pending_grants.push_back(g);
		items_sent++;
		if (op == OP_INIT && g.status == STAT_OK)
			held_blocks.delete();
		if (op != OP_FREE && op != OP_INIT && g.status == STAT_OK)
			held_blocks.push_back(g.block_address);
		if (op == OP_FREE && g.woken_valid)
			held_blocks.push_back(g.block_address);
	endtask

	// Lets every outstanding result drain so the registers can be rewritten.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (pending_grants.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Setup cycle, then access cycle; the write lands on the access edge. The
	// select is then dropped so back-to-back writes never overlap.
	task automatic reg_write(logic [1:0] index, logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {index, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		case (index)
			REG_POOL_BASE:   geo_base  = value;
			REG_BLOCK_BYTES: geo_bytes = value[15:0];
			REG_ALIGN_EIGHT: geo_eight = value[0];
			REG_BLOCK_COUNT: geo_count = value[5:0];
			default:         ;
		endcase
	endtask

	task automatic set_geometry(logic [31:0] base, logic [15:0] bytes, logic eight,
			logic [5:0] count);
		wait_idle();
		reg_write(REG_POOL_BASE, base);
		reg_write(REG_BLOCK_BYTES, {16'd0, bytes});
		reg_write(REG_ALIGN_EIGHT, {31'd0, eight});
		reg_write(REG_BLOCK_COUNT, {26'd0, count});
	endtask

	// Frees a block picked from the ones handed out so far.
	task automatic free_held();
		int          k;
		logic [31:0] a;
		if (held_blocks.size() == 0) begin
			issue_request(OP_FREE, $urandom, 8'($urandom), 8'($urandom));
		end else begin
			k = $urandom_range(0, held_blocks.size() - 1);
			a = held_blocks[k];
			held_blocks.delete(k);
			issue_request(OP_FREE, a, 8'($urandom), 8'($urandom));
		end
	endtask

	// Alloc and free before any init: the pool looks empty and every free is bad.
	task automatic test_before_init();
		issue_request(OP_ALLOC, 32'd0, 8'd0, 8'd0);
		issue_request(OP_ALLOC_WAIT, 32'd0, 8'hA5, 8'h5A);
		issue_request(OP_FREE, 32'd12, 8'd0, 8'd0);
		issue_request(OP_FREE, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
	endtask

	// Each way an init can fail, and a check that a failed init keeps the old pool.
	task automatic test_init_rejects();
		set_geometry(32'h0000_1000, 16'd0, 1'b0, 6'd4);
		issue_request(OP_INIT, 32'd0, 8'd0, 8'd0);
		// 65535 rounds up past the 16-bit size limit.
		set_geometry(32'h0000_1000, 16'hFFFF, 1'b1, 6'd1);
		issue_request(OP_INIT, 32'd0, 8'd0, 8'd0);
		// No blocks requested, so not even one block fits behind the header.
		set_geometry(32'h0000_1000, 16'd4, 1'b0, 6'd0);
		issue_request(OP_INIT, 32'd0, 8'd0, 8'd0);
		// Eight-byte rounding grows the header and block past what the pool size allows.
		set_geometry(32'h0000_1000, 16'd4, 1'b1, 6'd2);
		issue_request(OP_INIT, 32'd0, 8'd0, 8'd0);
		issue_request(OP_ALLOC, 32'd0, 8'd0, 8'd0);
	endtask

	// Pops, empty pool, queued waiters and bad pointers.
	// Base at the top of memory: block addresses wrap, so every free is a bad pointer.
	task automatic test_pool_ops();
		logic [31:0] first, second;
		set_geometry(32'hFFFF_FFFC, 16'd4, 1'b0, 6'd2);
		issue_request(OP_INIT, 32'd0, 8'd0, 8'd0);
		first  = 32'hFFFF_FFFC + 12;
		second = first + 4;
		issue_request(OP_ALLOC, 32'd0, 8'd0, 8'd0);
		issue_request(OP_ALLOC_WAIT, 32'd0, 8'd0, 8'd0);
		issue_request(OP_ALLOC, 32'd0, 8'd0, 8'd0);
		issue_request(OP_ALLOC_WAIT, 32'd0, 8'd1, 8'd5);
		issue_request(OP_ALLOC_WAIT, 32'd0, 8'd2, 8'd9);
		issue_request(OP_ALLOC_WAIT, 32'd0, 8'd3, 8'd5);
		issue_request(OP_FREE, first + 1, 8'd0, 8'd0);
		issue_request(OP_FREE, second + 4, 8'd0, 8'd0);
		issue_request(OP_FREE, first, 8'd0, 8'd0);
		issue_request(OP_FREE, second, 8'd0, 8'd0);
		issue_request(OP_FREE, first, 8'd0, 8'd0);
		issue_request(OP_FREE, first, 8'd0, 8'd0);
		// The wrapped address sits below the pool start, so this free is a bad pointer.
		issue_request(OP_FREE, second, 8'd0, 8'd0);
		issue_request(OP_FREE, second, 8'd0, 8'd0);
		// The pool is empty, so this alloc fails, and the free is again a bad pointer.
		issue_request(OP_ALLOC, 32'd0, 8'd0, 8'd0);
		issue_request(OP_FREE, second, 8'd0, 8'd0);
	endtask

	// Fills the wait queue to the brim on a one-block pool, then frees the block three times.
	task automatic test_wait_queue();
		set_geometry(32'h8000_0000, 16'd1, 1'b1, 6'd32);
		issue_request(OP_INIT, 32'd0, 8'd0, 8'd0);
		set_geometry(32'h0000_0040, 16'd4, 1'b0, 6'd1);
		issue_request(OP_INIT, 32'd0, 8'd0, 8'd0);
		issue_request(OP_ALLOC, 32'd0, 8'd0, 8'd0);
		for (int i = 0; i < WAIT_SLOTS + 1; i++)
			issue_request(OP_ALLOC_WAIT, 32'd0, 8'($urandom), 8'($urandom_range(0, 3)));
		repeat (3) free_held();
	endtask

	// Random phases: a fresh geometry, an init, then a mix of requests. Most
	// frees return blocks that are really out, so the wait queue fills and
	// drains; the rest are random or near-miss addresses and double frees.
	task automatic test_random_mix();
		int r, ops, k;
		while (items_sent < RANDOM_ITEMS - 100) begin
			r = $urandom_range(0, 9);
			set_geometry($urandom,
				(r < 7) ? 16'($urandom_range(1, 40)) :
				(r < 9) ? 16'($urandom_range(0, 3)) : 16'($urandom_range(65528, 65535)),
				1'($urandom_range(0, 1)),
				(r == 5) ? 6'd32 : 6'($urandom_range(0, 8)));
			issue_request(OP_INIT, $urandom, 8'($urandom), 8'($urandom));
			ops = $urandom_range(100, 250);
			for (int n = 0; n < ops; n++) begin
				r = $urandom_range(0, 99);
				if (r < 2) begin
					issue_request(OP_INIT, $urandom, 8'($urandom), 8'($urandom));
				end else if (r < 30) begin
					issue_request(OP_ALLOC, $urandom, 8'($urandom), 8'($urandom));
				end else if (r < 55) begin
					issue_request(OP_ALLOC_WAIT, $urandom, 8'($urandom), 8'($urandom));
				end else if (r < 85) begin
					free_held();
				end else if (r < 92) begin
					issue_request(OP_FREE, $urandom, 8'($urandom), 8'($urandom));
				end else begin
					// A block start, or one just off it, that may already be free.
					k = $urandom_range(0, POOL_SLOTS);
					issue_request(OP_FREE, block_at(k) + ((r < 96) ? 0 : $urandom_range(1, 3)),
						8'($urandom), 8'($urandom));
				end
			end
		end
	endtask

	// The receiver switches between free flow, random stalls and heavy stalls.
	int rx_mode = 0;
	int rx_hold = 0;
	always @(posedge clk) begin
		if (rx_hold == 0) begin
			rx_mode = $urandom_range(0, 3);
			rx_hold = $urandom_range(20, 200);
		end else begin
			rx_hold--;
		end
		case (rx_mode)
			0, 1:    m_tready <= 1'b1;
			2:       m_tready <= 1'($urandom_range(0, 1));
			default: m_tready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
		$display("mismatch at %0t: %s got 0x%0h, expected 0x%0h", $realtime, field, got, want);
		mismatches++;
	endtask

	// Every accepted result is held against the oldest expectation.
	always @(posedge clk) begin
		grant_t want;
		if (m_tvalid && m_tready) begin
			if (pending_grants.size() == 0) begin
				report_mismatch("unexpected result, status", 32'(m_tdata[2:0]), 32'd0);
			end else begin
				want = pending_grants.pop_front();
				if (m_tdata[2:0] !== want.status)
					report_mismatch("status", 32'(m_tdata[2:0]), 32'(want.status));
				if (m_tdata[34:3] !== want.block_address)
					report_mismatch("block_address", m_tdata[34:3], want.block_address);
				if (m_tdata[35] !== want.woken_valid)
					report_mismatch("woken_valid", 32'(m_tdata[35]), 32'(want.woken_valid));
				if (m_tdata[43:36] !== want.woken_task)
					report_mismatch("woken_task", 32'(m_tdata[43:36]), 32'(want.woken_task));
			end
		end
	end

	// Any handshake or register access counts as progress.
	int stall_cycles = 0;
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		// Shadow state starts out as the block does after reset.
		geo_base = '0;
		geo_bytes = '0;
		geo_eight = 1'b0;
		geo_count = '0;
		head_idx = 0;
		list_empty = 1'b1;
		blocks_usable = 0;
		block_stride = 0;
		header_stride = 0;
		blocks_free = 0;
		waiter_total = 0;
		for (int i = 0; i < POOL_SLOTS; i++)
			link_of[i] = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_before_init();
		test_init_rejects();
		test_pool_ops();
		test_wait_queue();
		test_random_mix();

		// Drain, then allow for the longest init before the final word.
		wait_idle();
		repeat (60) @(posedge clk);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
